>>> hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// pre holds -> post holds in the same cycle
`define ASSERT_IMPLY(name, clk, rst_n, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// pre holds -> post holds in the next cycle
`define ASSERT_NEXT(name, clk, rst_n, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> hdl/tdrt_pkg.sv
`timescale 1ns / 1ps
package tdrt_pkg;

  localparam int unsigned TilesAcrossDef = 4;
  localparam int unsigned TilesDownDef   = 4;
  localparam int unsigned TileEdgeDef    = 480;

  localparam int unsigned RectW    = 9;
  localparam int unsigned CoordW   = 16;  // covers tile and damage coordinates at the default tiling
  localparam int unsigned FracW    = 16;
  localparam int unsigned FixW     = 32;
  localparam int unsigned AccW     = 34;
  localparam int unsigned ProdW    = AccW + FixW;
  localparam int unsigned DimW     = 11;
  localparam int unsigned ViewW    = 12;
  localparam int unsigned DamPosW  = 13;
  localparam int unsigned DamSizeW = 12;
  localparam int unsigned IdxOutW  = 4;
  localparam int unsigned ResultCap = 16;
  localparam int unsigned CapW     = 5;

  localparam int unsigned InDataW  = 56;
  localparam int unsigned InUserW  = 2;
  localparam int unsigned OutDataW = 40;
  localparam int unsigned OutUserW = 4;
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 32;

  localparam logic [FixW-1:0] ZoomReset = 32'h0001_0000;

  // m_axis_tuser bit positions
  localparam int unsigned UserRedraw  = 0;
  localparam int unsigned UserPresent = 1;
  localparam int unsigned UserVisible = 2;
  localparam int unsigned UserUpload  = 3;

  typedef enum logic [1:0] {
    CmdDamage  = 2'd0,
    CmdFlush   = 2'd1,
    CmdMarkAll = 2'd2,
    CmdNop     = 2'd3
  } cmd_e;

  typedef enum logic [CfgAddrW-1:0] {
    CfgImageWidth  = 3'd0,
    CfgImageHeight = 3'd1,
    CfgShiftX      = 3'd2,
    CfgShiftY      = 3'd3,
    CfgZoomX       = 3'd4,
    CfgZoomY       = 3'd5,
    CfgViewWidth   = 3'd6,
    CfgViewHeight  = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [RectW-1:0] x;
    logic [RectW-1:0] y;
    logic [RectW-1:0] w;
    logic [RectW-1:0] h;
  } rect_t;

endpackage

>>> hdl/tdrt_ram.sv
`timescale 1ns / 1ps
module tdrt_ram #(
  parameter int unsigned Width = 36,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/tiled_dirty_rect_tracker_top.sv
`timescale 1ns / 1ps
// Channel  Dir  tdata                              tuser                        tlast
// s_axis   in   x[12:0] y[25:13] w[37:26] h[49:38] cmd[1:0]                     -
// m_axis   out  idx[3:0] rx ry rw rh (9b each)     redraw present visible upload last
// cfg      in   cfg_we_i, cfg_addr_i = register index, cfg_wdata_i
//
// Unless m_axis backpressure holds it, the walk moves one tile slot per cycle through
// the dirty-rect RAM (registered read, write-back).
// Reset clears control and config only; the next walk after reset or an image size write
// rewrites every slot with the fill pattern, so no clearing pass is run.
// m_axis backpressure holds the tile pipeline; s_axis is ready only while idle.
module tiled_dirty_rect_tracker_top import tdrt_pkg::*; #(
  parameter int unsigned TilesAcross = TilesAcrossDef,
  parameter int unsigned TilesDown   = TilesDownDef,
  parameter int unsigned TileEdge    = TileEdgeDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // damage_x, damage_y, damage_w, damage_h
  input  logic [InUserW-1:0]  s_axis_tuser,   // cmd
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // tile_index, rect_x, rect_y, rect_w, rect_h
  output logic [OutUserW-1:0] m_axis_tuser,   // redraw, tile_present, tile_visible, upload
  output logic                m_axis_tlast,
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  localparam int unsigned Slots  = TilesAcross * TilesDown;
  localparam int unsigned IdxW   = (Slots > 1) ? $clog2(Slots) : 1;
  localparam int unsigned EntryW = 4 * RectW;
  localparam logic signed [CoordW-1:0] EdgeC  = CoordW'(TileEdge);
  localparam logic signed [CoordW-1:0] LastPx = CoordW'((TilesAcross - 1) * TileEdge);
  localparam logic signed [CoordW-1:0] LastPy = CoordW'((TilesDown - 1) * TileEdge);
  localparam logic signed [AccW-1:0]   EdgeFx = AccW'(TileEdge) << FracW;
  localparam logic [IdxW-1:0]          LastIdx = IdxW'(Slots - 1);
  localparam logic [CapW-1:0]          CapLast = CapW'(ResultCap - 1);
  localparam logic [CapW-1:0]          CapC    = CapW'(ResultCap);

  typedef enum logic [3:0] {
    StIdle  = 4'b0001,
    StWalk  = 4'b0010,
    StDrain = 4'b0100,
    StResp  = 4'b1000
  } state_e;

  // configuration
  logic [DimW-1:0]         img_w_q, img_h_q;
  logic signed [FixW-1:0]  shift_x_q, shift_y_q, zoom_x_q, zoom_y_q;
  logic [ViewW-1:0]        view_w_q, view_h_q;
  logic                    dim_wr;

  assign dim_wr = cfg_we_i && (cfg_idx_e'(cfg_addr_i) == CfgImageWidth ||
                               cfg_idx_e'(cfg_addr_i) == CfgImageHeight);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_w_q   <= '0;
      img_h_q   <= '0;
      shift_x_q <= '0;
      shift_y_q <= '0;
      zoom_x_q  <= ZoomReset;
      zoom_y_q  <= ZoomReset;
      view_w_q  <= '0;
      view_h_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_addr_i))
        CfgImageWidth:  img_w_q   <= cfg_wdata_i[DimW-1:0];
        CfgImageHeight: img_h_q   <= cfg_wdata_i[DimW-1:0];
        CfgShiftX:      shift_x_q <= cfg_wdata_i;
        CfgShiftY:      shift_y_q <= cfg_wdata_i;
        CfgZoomX:       zoom_x_q  <= cfg_wdata_i;
        CfgZoomY:       zoom_y_q  <= cfg_wdata_i;
        CfgViewWidth:   view_w_q  <= cfg_wdata_i[ViewW-1:0];
        CfgViewHeight:  view_h_q  <= cfg_wdata_i[ViewW-1:0];
      endcase
    end
  end

  // input decode
  cmd_e                     in_cmd;
  logic signed [CoordW-1:0] in_x, in_y, in_x2, in_y2;
  logic                     in_fire;

  assign in_cmd = cmd_e'(s_axis_tuser);
  assign in_x   = CoordW'($signed(s_axis_tdata[12:0]));
  assign in_y   = CoordW'($signed(s_axis_tdata[25:13]));
  assign in_x2  = in_x + $signed({{(CoordW-DamSizeW){1'b0}}, s_axis_tdata[37:26]});
  assign in_y2  = in_y + $signed({{(CoordW-DamSizeW){1'b0}}, s_axis_tdata[49:38]});

  // control and walk state
  state_e                   state_q, state_d;
  cmd_e                     cmd_q, cmd_d;
  logic signed [CoordW-1:0] dx_q, dy_q, dx2_q, dy2_q;
  logic signed [CoordW-1:0] px_q, px_d, py_q, py_d;
  logic signed [AccW-1:0]   ax_q, ax_d, ay_q, ay_d;
  logic [IdxW-1:0]          idx_q, idx_d;
  logic [CapW-1:0]          k_q, k_d;
  logic                     redraw_q, redraw_d;
  logic                     fill_q, fill_d;
  logic                     fill_pend_q, fill_pend_d;

  // stage A: tile geometry, clipping, products
  logic signed [CoordW-1:0] img_w_c, img_h_c, rem_x, rem_y, pw_a, ph_a;
  logic                     exist_a, touch_a, emit_a, last_a;
  logic [2*RectW-1:0]       clip_x, clip_y;
  logic signed [AccW-1:0]   a2x, a2y;
  logic                     okx_a, oky_a;
  logic signed [ProdW-1:0]  prod_x, prod_y;
  logic                     issue, adv;

  function automatic logic [2*RectW-1:0] clip_axis(
    input logic signed [CoordW-1:0] a,
    input logic signed [CoordW-1:0] a2,
    input logic signed [CoordW-1:0] p,
    input logic signed [CoordW-1:0] pl
  );
    logic signed [CoordW-1:0] v;
    logic signed [CoordW-1:0] ml;
    v = a - p;
    if (v < 0) begin
      v = '0;
    end
    ml = a2 - (p + v);
    if (ml + v > pl) begin
      ml = pl - v;
    end
    return {v[RectW-1:0], ml[RectW-1:0]};
  endfunction

  assign img_w_c = $signed({{(CoordW-DimW){1'b0}}, img_w_q});
  assign img_h_c = $signed({{(CoordW-DimW){1'b0}}, img_h_q});
  assign rem_x   = img_w_c - px_q;
  assign rem_y   = img_h_c - py_q;
  assign pw_a    = (rem_x > EdgeC) ? EdgeC : rem_x;
  assign ph_a    = (rem_y > EdgeC) ? EdgeC : rem_y;
  assign exist_a = (px_q < img_w_c) && (py_q < img_h_c);
  assign touch_a = exist_a && (px_q <= dx2_q) && (py_q <= dy2_q) &&
                   (px_q + pw_a >= dx_q) && (py_q + ph_a >= dy_q);
  assign clip_x  = clip_axis(dx_q, dx2_q, px_q, pw_a);
  assign clip_y  = clip_axis(dy_q, dy2_q, py_q, ph_a);
  assign emit_a  = (cmd_q == CmdFlush) && exist_a && (k_q < CapC);
  assign last_a  = (k_q == CapLast) ||
                   (((px_q == LastPx) || (px_q + EdgeC >= img_w_c)) &&
                    ((py_q == LastPy) || (py_q + EdgeC >= img_h_c)));

  assign a2x = ax_q + $signed({{(AccW-RectW-FracW){1'b0}}, pw_a[RectW-1:0], {FracW{1'b0}}});
  assign a2y = ay_q + $signed({{(AccW-RectW-FracW){1'b0}}, ph_a[RectW-1:0], {FracW{1'b0}}});
  assign okx_a = (a2x == '0) || (zoom_x_q == '0) || (a2x[AccW-1] == zoom_x_q[FixW-1]);
  assign oky_a = (a2y == '0) || (zoom_y_q == '0) || (a2y[AccW-1] == zoom_y_q[FixW-1]);
  assign prod_x = ax_q * zoom_x_q;
  assign prod_y = ay_q * zoom_y_q;

  // stage B: read data back, merge or clear, write back, emit
  logic                    b_valid_q, b_valid_d;
  logic [IdxW-1:0]         b_idx_q;
  logic                    b_exist_q, b_touch_q, b_emit_q, b_last_q, b_okx_q, b_oky_q;
  logic [RectW-1:0]        b_mx_q, b_my_q, b_mw_q, b_mh_q, b_pw_q, b_ph_q;
  logic signed [ProdW-1:0] b_prod_x_q, b_prod_y_q;
  logic signed [ProdW-1:0] lim_x, lim_y;
  logic                    vis_b, b_go, b_fire, out_free;
  logic [EntryW-1:0]       rdata;
  rect_t                   base, merged, new_rect, fill_rect;
  logic [RectW:0]          old_x2, old_y2, clp_x2, clp_y2, max_x2, max_y2;
  logic [RectW-1:0]        min_x, min_y;
  logic                    clip_ne, base_ne, dmg_wr, up_b, ram_we;

  assign lim_x = $signed({{(ProdW-ViewW-FixW){1'b0}}, view_w_q,
                          {(FixW-FracW-1){1'b0}}, 1'b1, {FracW{1'b0}}});
  assign lim_y = $signed({{(ProdW-ViewW-FixW){1'b0}}, view_h_q,
                          {(FixW-FracW-1){1'b0}}, 1'b1, {FracW{1'b0}}});
  assign vis_b = b_okx_q && (b_prod_x_q < lim_x) && b_oky_q && (b_prod_y_q < lim_y);

  assign fill_rect = b_exist_q ? rect_t'{x: '0, y: '0, w: b_pw_q, h: b_ph_q} : '0;
  assign base      = fill_q ? fill_rect : rect_t'(rdata);

  assign old_x2 = {1'b0, base.x} + {1'b0, base.w};
  assign old_y2 = {1'b0, base.y} + {1'b0, base.h};
  assign clp_x2 = {1'b0, b_mx_q} + {1'b0, b_mw_q};
  assign clp_y2 = {1'b0, b_my_q} + {1'b0, b_mh_q};
  assign max_x2 = (clp_x2 > old_x2) ? clp_x2 : old_x2;
  assign max_y2 = (clp_y2 > old_y2) ? clp_y2 : old_y2;
  assign min_x  = (b_mx_q < base.x) ? b_mx_q : base.x;
  assign min_y  = (b_my_q < base.y) ? b_my_q : base.y;

  assign clip_ne = (b_mw_q != '0) && (b_mh_q != '0);
  assign base_ne = (base.w != '0) && (base.h != '0);

  always_comb begin
    if (base_ne) begin
      merged.x = min_x;
      merged.y = min_y;
      merged.w = RectW'(max_x2 - {1'b0, min_x});
      merged.h = RectW'(max_y2 - {1'b0, min_y});
    end else begin
      merged.x = b_mx_q;
      merged.y = b_my_q;
      merged.w = b_mw_q;
      merged.h = b_mh_q;
    end
  end

  assign dmg_wr = (cmd_q == CmdDamage) && b_touch_q && clip_ne;
  assign up_b   = (cmd_q == CmdFlush) && b_emit_q && vis_b && base_ne;

  always_comb begin
    priority if (dmg_wr) begin
      new_rect = merged;
    end else if (up_b) begin
      new_rect = '0;
    end else begin
      new_rect = base;
    end
  end

  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign b_go     = !b_emit_q || out_free;
  assign b_fire   = b_valid_q && b_go;
  assign adv      = !b_valid_q || b_go;
  assign issue    = (state_q == StWalk) && adv;
  assign ram_we   = b_fire && (fill_q || dmg_wr || up_b);

  assign s_axis_tready = (state_q == StIdle);

  tdrt_ram #(
    .Width (EntryW),
    .Depth (Slots)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (b_idx_q),
    .wdata_i (new_rect),
    .re_i    (issue),
    .raddr_i (idx_q),
    .rdata_o (rdata)
  );

  // sequencer
  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    px_d        = px_q;
    py_d        = py_q;
    ax_d        = ax_q;
    ay_d        = ay_q;
    idx_d       = idx_q;
    k_d         = k_q;
    redraw_d    = redraw_q;
    fill_d      = fill_q;
    fill_pend_d = fill_pend_q;
    b_valid_d   = b_valid_q;
    in_fire     = 1'b0;

    unique case (state_q)
      StIdle: begin
        if (s_axis_tvalid) begin
          in_fire  = 1'b1;
          cmd_d    = in_cmd;
          redraw_d = 1'b0;
          k_d      = '0;
          if (in_cmd == CmdNop) begin
            state_d = StResp;
          end else begin
            state_d     = StWalk;
            fill_d      = fill_pend_q || (in_cmd == CmdMarkAll);
            fill_pend_d = 1'b0;
            px_d        = '0;
            py_d        = '0;
            ax_d        = AccW'(shift_x_q);
            ay_d        = AccW'(shift_y_q);
            idx_d       = '0;
          end
        end
      end
      StWalk: begin
        if (issue) begin
          idx_d = idx_q + 1'b1;
          if (emit_a) begin
            k_d = k_q + 1'b1;
          end
          if (px_q == LastPx) begin
            px_d = '0;
            ax_d = AccW'(shift_x_q);
            py_d = py_q + EdgeC;
            ay_d = ay_q + EdgeFx;
          end else begin
            px_d = px_q + EdgeC;
            ax_d = ax_q + EdgeFx;
          end
          if (idx_q == LastIdx) begin
            state_d = StDrain;
          end
        end
      end
      StDrain: begin
        if (!b_valid_q) begin
          state_d = ((cmd_q == CmdFlush) && (k_q != '0)) ? StIdle : StResp;
        end
      end
      StResp: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase

    if (issue) begin
      b_valid_d = 1'b1;
    end else if (b_fire) begin
      b_valid_d = 1'b0;
    end

    if (b_fire && (cmd_q == CmdDamage) && b_touch_q && vis_b) begin
      redraw_d = 1'b1;
    end

    if (dim_wr) begin
      fill_pend_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cmd_q       <= CmdNop;
      idx_q       <= '0;
      k_q         <= '0;
      redraw_q    <= 1'b0;
      fill_q      <= 1'b0;
      fill_pend_q <= 1'b1;
      b_valid_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      cmd_q       <= cmd_d;
      idx_q       <= idx_d;
      k_q         <= k_d;
      redraw_q    <= redraw_d;
      fill_q      <= fill_d;
      fill_pend_q <= fill_pend_d;
      b_valid_q   <= b_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    px_q <= px_d;
    py_q <= py_d;
    ax_q <= ax_d;
    ay_q <= ay_d;
    if (in_fire) begin
      dx_q  <= in_x;
      dy_q  <= in_y;
      dx2_q <= in_x2;
      dy2_q <= in_y2;
    end
    if (issue) begin
      b_idx_q    <= idx_q;
      b_exist_q  <= exist_a;
      b_touch_q  <= touch_a;
      b_emit_q   <= emit_a;
      b_last_q   <= last_a;
      b_okx_q    <= okx_a;
      b_oky_q    <= oky_a;
      b_mx_q     <= clip_x[2*RectW-1:RectW];
      b_mw_q     <= clip_x[RectW-1:0];
      b_my_q     <= clip_y[2*RectW-1:RectW];
      b_mh_q     <= clip_y[RectW-1:0];
      b_pw_q     <= pw_a[RectW-1:0];
      b_ph_q     <= ph_a[RectW-1:0];
      b_prod_x_q <= prod_x;
      b_prod_y_q <= prod_y;
    end
  end

  // output register
  logic                out_valid_q, out_valid_d;
  logic                load_tile, load_resp;
  logic [OutDataW-1:0] out_data_q;
  logic [OutUserW-1:0] out_user_q;
  logic                out_last_q;
  rect_t               up_rect;

  assign load_tile = b_fire && b_emit_q;
  assign load_resp = (state_q == StResp) && out_free;
  assign up_rect   = up_b ? base : '0;

  always_comb begin
    if (load_tile || load_resp) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_tile) begin
      out_data_q <= {up_rect.h, up_rect.w, up_rect.y, up_rect.x, IdxOutW'(b_idx_q)};
      out_user_q <= {up_b, vis_b, 1'b1, 1'b0};
      out_last_q <= b_last_q;
    end else if (load_resp) begin
      out_data_q <= '0;
      out_user_q <= {1'b0, 1'b0, 1'b0, redraw_q};
      out_last_q <= 1'b1;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;
  assign m_axis_tlast  = out_last_q;

endmodule

>>> hdl/tdrt_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tdrt_checker import tdrt_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata,   // tile_index, rect_x, rect_y, rect_w, rect_h
  input logic [OutUserW-1:0] m_axis_tuser,   // redraw, tile_present, tile_visible, upload
  input logic                m_axis_tlast
);

  // redraw only on the single non-tile result
  `ASSERT_IMPLY(a_redraw_single, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser[UserRedraw], m_axis_tlast && !m_axis_tuser[UserPresent], "redraw on a tile result")

  `ASSERT_IMPLY(a_upload_visible, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser[UserUpload], m_axis_tuser[UserPresent] && m_axis_tuser[UserVisible], "upload from a hidden or absent tile")

  `ASSERT_IMPLY(a_absent_empty, clk_i, rst_ni, m_axis_tvalid && !m_axis_tuser[UserPresent], m_axis_tlast && (m_axis_tdata == '0), "non-tile result not empty")

  `ASSERT_IMPLY(a_no_upload_rect, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser[UserPresent] && !m_axis_tuser[UserUpload], m_axis_tdata[OutDataW-1:IdxOutW] == '0, "rect without upload")

  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled transfer changed")

endmodule

bind tiled_dirty_rect_tracker_top tdrt_checker u_tdrt_checker (.*);

>>> bench/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import tdrt_pkg::*;

  localparam int Slots        = TilesAcrossDef * TilesDownDef;
  localparam int SettleCycles = Slots + 8;
  localparam int HoldCycles   = 400;
  localparam int CycleLimit   = 400000;

  typedef struct packed {
    bit       redraw;
    bit       present;
    bit [3:0] idx;
    bit       visible;
    bit       upload;
    bit [8:0] rx;
    bit [8:0] ry;
    bit [8:0] rw;
    bit [8:0] rh;
    bit       last;
  } tile_report_t;

  typedef struct {
    bit        is_cfg;
    cfg_idx_e  reg_idx;
    logic [31:0] value;
    cmd_e      op;
    int        x, y, w, h;
    bit        typed;
    bit        redraw;
  } stim_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic [InUserW-1:0]  s_axis_tuser = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [OutUserW-1:0] m_axis_tuser;
  logic                m_axis_tlast;
  logic                cfg_we = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;

  tiled_dirty_rect_tracker_top dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we),
    .cfg_addr_i    (cfg_addr),
    .cfg_wdata_i   (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // tracker state as seen by the bench
  int img_w, img_h, view_w, view_h;
  logic signed [31:0] shift_x, shift_y, zoom_x, zoom_y;
  int rect_x[Slots], rect_y[Slots], rect_w[Slots], rect_h[Slots];

  tile_report_t tile_reports_due[$];
  stim_row_t    stim_rows[$];

  int  errors, items_sent, reports_checked, uploads_seen, cfg_writes, cycle_count;
  int  send_idle_pct, stall_pct;
  bit  want_hold, hold_done, need_settle;
  int  hold_left;

  function automatic int tiles_along(int size, int limit);
    int n;
    n = (size + TileEdgeDef - 1) / TileEdgeDef;
    return (n > limit) ? limit : n;
  endfunction

  function automatic int tile_span(int size, int start);
    int e;
    e = size - start;
    return (e > TileEdgeDef) ? TileEdgeDef : e;
  endfunction

  function automatic bit axis_visible(logic signed [31:0] sh, logic signed [31:0] zm,
                                      int lo, int hi, int view);
    longint s, z, p1, p2, lim;
    s   = sh;
    z   = zm;
    p1  = (s + longint'(lo) * 65536) * z;
    p2  = (s + longint'(hi) * 65536) * z;
    lim = (longint'(view) * 65536 + 1) * 65536;
    return (p2 >= 0) && (p1 < lim);
  endfunction

  function automatic bit tile_on_screen(int px, int pw, int py, int ph);
    return axis_visible(shift_x, zoom_x, px, px + pw, view_w) &&
           axis_visible(shift_y, zoom_y, py, py + ph, view_h);
  endfunction

  function automatic void mark_all_dirty();
    int na, nd, i;
    na = tiles_along(img_w, TilesAcrossDef);
    nd = tiles_along(img_h, TilesDownDef);
    for (int k = 0; k < Slots; k++) begin
      rect_x[k] = 0; rect_y[k] = 0; rect_w[k] = 0; rect_h[k] = 0;
    end
    for (int r = 0; r < nd; r++) begin
      for (int c = 0; c < na; c++) begin
        i = r * TilesAcrossDef + c;
        rect_w[i] = tile_span(img_w, c * TileEdgeDef);
        rect_h[i] = tile_span(img_h, r * TileEdgeDef);
      end
    end
  endfunction

  function automatic void clip_axis(input int a, input int a2, input int p, input int pl,
                                    output int m, output int ml);
    int v;
    v = a - p;
    if (v < 0) v = 0;
    m  = v;
    ml = a2 - (p + v);
    if (ml + v > pl) ml = pl - v;
  endfunction

  function automatic void apply_register(cfg_idx_e idx, logic [31:0] v);
    case (idx)
      CfgImageWidth: begin
        img_w = int'(v[DimW-1:0]);
        mark_all_dirty();
      end
      CfgImageHeight: begin
        img_h = int'(v[DimW-1:0]);
        mark_all_dirty();
      end
      CfgShiftX:     shift_x = v;
      CfgShiftY:     shift_y = v;
      CfgZoomX:      zoom_x = v;
      CfgZoomY:      zoom_y = v;
      CfgViewWidth:  view_w = int'(v[ViewW-1:0]);
      CfgViewHeight: view_h = int'(v[ViewW-1:0]);
      default: ;
    endcase
  endfunction

  // updates the dirty rectangles for one command and returns the tile reports it causes
  function automatic void track_command(input cmd_e op, input int x, input int y,
                                        input int w, input int h, ref tile_report_t reps[$]);
    int na, nd, i, px, py, pw, ph, mx, my, mw, mh, nx, ny, ox2, oy2, x2, y2, k;
    bit redraw, vis;
    tile_report_t rep;
    na = tiles_along(img_w, TilesAcrossDef);
    nd = tiles_along(img_h, TilesDownDef);
    rep = '0;
    case (op)
      CmdDamage: begin
        x2 = x + w;
        y2 = y + h;
        redraw = 1'b0;
        for (int r = 0; r < nd; r++) begin
          for (int c = 0; c < na; c++) begin
            i  = r * TilesAcrossDef + c;
            px = c * TileEdgeDef;
            py = r * TileEdgeDef;
            pw = tile_span(img_w, px);
            ph = tile_span(img_h, py);
            if (!(px <= x2 && py <= y2 && px + pw >= x && py + ph >= y)) continue;
            clip_axis(x, x2, px, pw, mx, mw);
            clip_axis(y, y2, py, ph, my, mh);
            if (mw > 0 && mh > 0) begin
              if (rect_w[i] > 0 && rect_h[i] > 0) begin
                ox2 = rect_x[i] + rect_w[i];
                oy2 = rect_y[i] + rect_h[i];
                nx  = (mx < rect_x[i]) ? mx : rect_x[i];
                ny  = (my < rect_y[i]) ? my : rect_y[i];
                if (mx + mw > ox2) ox2 = mx + mw;
                if (my + mh > oy2) oy2 = my + mh;
                rect_x[i] = nx;
                rect_y[i] = ny;
                rect_w[i] = ox2 - nx;
                rect_h[i] = oy2 - ny;
              end else begin
                rect_x[i] = mx; rect_y[i] = my; rect_w[i] = mw; rect_h[i] = mh;
              end
            end
            if (tile_on_screen(px, pw, py, ph)) redraw = 1'b1;
          end
        end
        rep.redraw = redraw;
        rep.last   = 1'b1;
        reps.push_back(rep);
      end
      CmdFlush: begin
        k = 0;
        for (int r = 0; r < nd; r++) begin
          for (int c = 0; c < na; c++) begin
            i  = r * TilesAcrossDef + c;
            px = c * TileEdgeDef;
            py = r * TileEdgeDef;
            pw = tile_span(img_w, px);
            ph = tile_span(img_h, py);
            if (k >= ResultCap) continue;
            vis = tile_on_screen(px, pw, py, ph);
            rep = '0;
            rep.present = 1'b1;
            rep.idx     = i[3:0];
            rep.visible = vis;
            if (vis && rect_w[i] > 0 && rect_h[i] > 0) begin
              rep.upload = 1'b1;
              rep.rx = rect_x[i][8:0];
              rep.ry = rect_y[i][8:0];
              rep.rw = rect_w[i][8:0];
              rep.rh = rect_h[i][8:0];
              rect_x[i] = 0; rect_y[i] = 0; rect_w[i] = 0; rect_h[i] = 0;
            end
            reps.push_back(rep);
            k++;
          end
        end
        if (k == 0) begin
          rep = '0;
          rep.last = 1'b1;
          reps.push_back(rep);
        end else begin
          rep = reps.pop_back();
          rep.last = 1'b1;
          reps.push_back(rep);
        end
      end
      CmdMarkAll: begin
        mark_all_dirty();
        rep.last = 1'b1;
        reps.push_back(rep);
      end
      default: begin
        rep.last = 1'b1;
        reps.push_back(rep);
      end
    endcase
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  function automatic void add_item(cmd_e op, int x, int y, int w, int h,
                                   bit typed = 1'b0, bit redraw = 1'b0);
    stim_row_t row;
    row.is_cfg = 1'b0;
    row.reg_idx = CfgImageWidth;
    row.value = '0;
    row.op = op;
    row.x = x; row.y = y; row.w = w; row.h = h;
    row.typed = typed;
    row.redraw = redraw;
    stim_rows.push_back(row);
  endfunction

  function automatic void add_cfg(cfg_idx_e idx, logic [31:0] v);
    stim_row_t row;
    row.is_cfg = 1'b1;
    row.reg_idx = idx;
    row.value = v;
    row.op = CmdNop;
    row.x = 0; row.y = 0; row.w = 0; row.h = 0;
    row.typed = 1'b0;
    row.redraw = 1'b0;
    stim_rows.push_back(row);
  endfunction

  // block must be idle before a register write
  task automatic settle();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (tile_reports_due.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    need_settle = 1'b0;
  endtask

  task automatic cfg_write(cfg_idx_e idx, logic [31:0] v);
    if (need_settle) settle();
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_addr  = idx;
    cfg_wdata = v;
    apply_register(idx, v);
    cfg_writes++;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic drive_item(cmd_e op, int x, int y, int w, int h, bit typed, bit redraw);
    tile_report_t reps[$];
    tile_report_t rep;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {6'b0, 12'(h), 12'(w), 13'(y), 13'(x)};
    s_axis_tuser  = op;
    do @(posedge clk); while (!s_axis_tready);
    items_sent++;
    need_settle = 1'b1;
    track_command(op, x, y, w, h, reps);
    if (typed) begin
      rep = '0;
      rep.redraw = redraw;
      rep.last = 1'b1;
      tile_reports_due.push_back(rep);
    end else begin
      foreach (reps[n]) tile_reports_due.push_back(reps[n]);
    end
  endtask

  function automatic int pick_dim();
    case ($urandom_range(5))
      0: return 1920;
      1: return 1000;
      2: return int'($urandom_range(1, 480));
      3: return 481;
      4: return int'($urandom_range(0, 1920));
      default: return 960;
    endcase
  endfunction

  function automatic logic [31:0] pick_shift();
    if ($urandom_range(3) == 0) return $urandom;
    return (int'($urandom_range(600)) - 300) * 65536 + int'($urandom_range(65535));
  endfunction

  function automatic logic [31:0] pick_zoom();
    case ($urandom_range(4))
      0: return $urandom;
      1: return -int'($urandom_range(32'h8000, 32'h20000));
      default: return int'($urandom_range(32'h4000, 32'h30000));
    endcase
  endfunction

  function automatic int pick_view();
    if ($urandom_range(3) == 0) return int'($urandom_range(4095));
    return int'($urandom_range(200, 2000));
  endfunction

  task automatic random_setting();
    if ($urandom_range(1)) cfg_write(CfgImageWidth, pick_dim());
    if ($urandom_range(1)) cfg_write(CfgImageHeight, pick_dim());
    cfg_write(CfgShiftX, pick_shift());
    cfg_write(CfgShiftY, pick_shift());
    cfg_write(CfgZoomX, pick_zoom());
    cfg_write(CfgZoomY, pick_zoom());
    cfg_write(CfgViewWidth, pick_view());
    cfg_write(CfgViewHeight, pick_view());
  endtask

  task automatic random_item();
    int sel, x, y, w, h;
    cmd_e op;
    sel = $urandom_range(99);
    op = (sel < 58) ? CmdDamage : (sel < 83) ? CmdFlush : (sel < 92) ? CmdMarkAll : CmdNop;
    if ($urandom_range(4) == 0) begin
      x = int'($urandom_range(8191)) - 4096;
      y = int'($urandom_range(8191)) - 4096;
      w = int'($urandom_range(4095));
      h = int'($urandom_range(4095));
    end else begin
      x = int'($urandom_range(img_w + 60)) - 30;
      y = int'($urandom_range(img_h + 60)) - 30;
      w = ($urandom_range(3) == 0) ? int'($urandom_range(2000)) : int'($urandom_range(200));
      h = ($urandom_range(3) == 0) ? int'($urandom_range(2000)) : int'($urandom_range(200));
    end
    drive_item(op, x, y, w, h, 1'b0, 1'b0);
  endtask

  always @(negedge clk) begin
    if (want_hold && !hold_done) begin
      hold_left = HoldCycles;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready = 1'b0;
    end else begin
      m_axis_tready = ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    tile_report_t got, want;
    if (rst_n && m_axis_tvalid && m_axis_tready) begin
      got.redraw  = m_axis_tuser[UserRedraw];
      got.present = m_axis_tuser[UserPresent];
      got.visible = m_axis_tuser[UserVisible];
      got.upload  = m_axis_tuser[UserUpload];
      got.idx     = m_axis_tdata[3:0];
      got.rx      = m_axis_tdata[12:4];
      got.ry      = m_axis_tdata[21:13];
      got.rw      = m_axis_tdata[30:22];
      got.rh      = m_axis_tdata[39:31];
      got.last    = m_axis_tlast;
      if (tile_reports_due.size() == 0) begin
        $error("unexpected output transfer: tdata %h tuser %h", m_axis_tdata, m_axis_tuser);
        errors++;
      end else begin
        want = tile_reports_due.pop_front();
        check_field("redraw", want.redraw, got.redraw);
        check_field("tile_present", want.present, got.present);
        check_field("tile_index", want.idx, got.idx);
        check_field("tile_visible", want.visible, got.visible);
        check_field("upload", want.upload, got.upload);
        check_field("rect_x", want.rx, got.rx);
        check_field("rect_y", want.ry, got.ry);
        check_field("rect_w", want.rw, got.rw);
        check_field("rect_h", want.rh, got.rh);
        check_field("last", want.last, got.last);
        reports_checked++;
        if (got.upload) uploads_seen++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d reports outstanding",
               cycle_count, tile_reports_due.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int send_mode[6];
    int stall_mode[6];
    send_mode  = '{0, 51, 0, 36, 0, 36};
    stall_mode = '{0, 0, 51, 36, 0, 36};
    img_w = 0; img_h = 0; view_w = 0; view_h = 0;
    shift_x = '0; shift_y = '0; zoom_x = ZoomReset; zoom_y = ZoomReset;
    for (int k = 0; k < Slots; k++) begin
      rect_x[k] = 0; rect_y[k] = 0; rect_w[k] = 0; rect_h[k] = 0;
    end
    errors = 0; items_sent = 0; reports_checked = 0; uploads_seen = 0;
    cfg_writes = 0; cycle_count = 0; hold_left = 0;
    send_idle_pct = 0; stall_pct = 0;
    want_hold = 1'b0; hold_done = 1'b0; need_settle = 1'b0;

    // no tiles after reset
    add_item(CmdNop, 0, 0, 0, 0, 1'b1, 1'b0);
    add_item(CmdFlush, 0, 0, 0, 0, 1'b1, 1'b0);
    add_item(CmdDamage, 0, 0, 100, 100, 1'b1, 1'b0);
    add_item(CmdMarkAll, 0, 0, 0, 0, 1'b1, 1'b0);
    add_cfg(CfgViewWidth, 1920);
    add_cfg(CfgViewHeight, 1080);
    add_cfg(CfgImageWidth, 1920);
    add_cfg(CfgImageHeight, 1920);
    add_item(CmdFlush, 0, 0, 0, 0);
    add_item(CmdDamage, -4096, -4096, 4095, 4095, 1'b1, 1'b0);
    add_item(CmdDamage, 4095, 4095, 4095, 4095, 1'b1, 1'b0);
    // zero-size damage on a shared corner: no merge, still redraws
    add_item(CmdDamage, 480, 480, 0, 0, 1'b1, 1'b1);
    add_item(CmdDamage, 0, 1919, 10, 1);
    add_item(CmdDamage, 100, 100, 50, 50);
    add_item(CmdDamage, 300, 20, 400, 10);
    add_item(CmdDamage, 1919, 1079, 1, 1);
    add_item(CmdFlush, 0, 0, 0, 0);
    add_item(CmdDamage, -10, -10, 4095, 4095);
    add_item(CmdFlush, 0, 0, 0, 0);
    add_item(CmdMarkAll, 0, 0, 0, 0, 1'b1, 1'b0);
    add_cfg(CfgZoomX, 32'hFFFF_0000);
    add_item(CmdDamage, 0, 0, 10, 10, 1'b1, 1'b0);
    add_item(CmdFlush, 0, 0, 0, 0);
    add_cfg(CfgZoomX, 32'h0001_0000);
    add_cfg(CfgShiftX, 32'hF880_0000);
    add_cfg(CfgShiftY, 32'h8000_0000);
    add_cfg(CfgZoomY, 32'h7FFF_FFFF);
    add_item(CmdFlush, 0, 0, 0, 0);
    add_cfg(CfgShiftY, 32'h7FFF_FFFF);
    add_cfg(CfgZoomY, 32'h0000_0000);
    add_cfg(CfgViewWidth, 0);
    add_item(CmdDamage, 1440, 0, 479, 1);
    add_item(CmdFlush, 0, 0, 0, 0);
    add_cfg(CfgImageWidth, 1000);
    add_cfg(CfgImageHeight, 1);
    add_item(CmdFlush, 0, 0, 0, 0);
    add_item(CmdDamage, 999, 0, 1, 1);
    add_item(CmdFlush, 0, 0, 0, 0);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (stim_rows[n]) begin
      if (stim_rows[n].is_cfg) cfg_write(stim_rows[n].reg_idx, stim_rows[n].value);
      else drive_item(stim_rows[n].op, stim_rows[n].x, stim_rows[n].y, stim_rows[n].w,
                      stim_rows[n].h, stim_rows[n].typed, stim_rows[n].redraw);
    end

    for (int p = 0; p < 6; p++) begin
      random_setting();
      send_idle_pct = send_mode[p];
      stall_pct     = stall_mode[p];
      // long output hold-off while items keep coming
      if (p == 4) want_hold = 1'b1;
      repeat (15) random_item();
    end

    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (tile_reports_due.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);

    $display("%0d commands sent over %0d register writes, %0d tile reports checked",
             items_sent, cfg_writes, reports_checked);
    $display("%0d dirty rectangles handed out for upload, %0d mismatches",
             uploads_seen, errors);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hdl
hdl/tdrt_pkg.sv
hdl/tdrt_ram.sv
hdl/tiled_dirty_rect_tracker_top.sv
hdl/tdrt_checker.sv
bench/tb_top.sv
